@@ sv/sdspi_pkg.sv @@
// Shared types, codes and command byte helpers for the SD SPI command engine.
`timescale 1ns / 1ps

package sdspi_pkg;

	// op codes of an input word
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_RX    = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// configuration register indexes
	localparam logic CFG_READY_TIMEOUT  = 1'b0;
	localparam logic CFG_RESPONSE_POLLS = 1'b1;

	localparam logic [15:0] READY_TIMEOUT_RST  = 16'd500;
	localparam logic [3:0]  RESPONSE_POLLS_RST = 4'd10;

	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_SEND_IF   = 6'd8;
	localparam logic [5:0] CMD_STOP      = 6'd12;
	localparam logic [5:0] CMD_APP_OP    = 6'd41;
	localparam logic [5:0] CMD_APP       = 6'd55;

	localparam logic [7:0] BYTE_IDLE     = 8'hFF;
	localparam logic [7:0] R1_NO_RESP    = 8'h80;
	localparam logic [7:0] R1_TIMEOUT    = 8'hFF;
	localparam logic [2:0] LAST_CMD_BYTE = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_DESEL   = 3'd1,
		PH_SEL     = 3'd2,
		PH_WAIT    = 3'd3,
		PH_TODESEL = 3'd4,
		PH_SEND    = 3'd5,
		PH_STUFF   = 3'd6,
		PH_RESP    = 3'd7
	} phase_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [5:0]  cmd_index;
		logic        app_cmd;
		logic [31:0] cmd_arg;
		logic [7:0]  rx_byte;
	} sdspi_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic       chip_select_low;
		logic [7:0] r1;
		logic       timed_out;
		logic       last;
	} sdspi_result_t;

	// fixed CRC7 byte for the commands that need a valid one
	function automatic logic [7:0] cmd_crc(input logic [5:0] idx);
		logic [7:0] crc;
		unique case (idx)
			CMD_GO_IDLE: crc = 8'h95;
			CMD_SEND_IF: crc = 8'h87;
			CMD_APP:     crc = 8'h65;
			CMD_APP_OP:  crc = 8'h77;
			default:     crc = 8'h01;
		endcase
		return crc;
	endfunction

	// byte k of the six-byte command frame
	function automatic logic [7:0] cmd_byte(input logic [5:0] idx, input logic [31:0] arg,
			input logic [2:0] k);
		logic [7:0] b;
		unique case (k)
			3'd0:    b = {2'b01, idx};
			3'd1:    b = arg[31:24];
			3'd2:    b = arg[23:16];
			3'd3:    b = arg[15:8];
			3'd4:    b = arg[7:0];
			default: b = cmd_crc(idx);
		endcase
		return b;
	endfunction

endpackage

@@ sv/sd_spi_command_transaction.sv @@
// Top level of the SD SPI-mode command engine: input stage, config regs, result register.
`timescale 1ns / 1ps
// An accepted word is held in the input stage and written to the result register when it
// advances, so it sits on rsp from then until it is taken.
// Throughput: one word per cycle, so
// cmd_stall rises only when the result register is full and rsp_stall holds it.
// Ticks, ignored starts and stray bytes take their slot but give no result word.
// Reset (arst_n low) puts the sequencer idle with CS high, clears both stages
// and loads ready_timeout_ms = 500, response_polls = 10.

module sd_spi_command_transaction (
	input  logic                     clk,
	input  logic                     arst_n,
	// input words
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  sdspi_pkg::sdspi_item_t   cmd,
	// result words
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output sdspi_pkg::sdspi_result_t rsp,
	// configuration writes
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [15:0]              cfg_data
);
	import sdspi_pkg::*;

	// input stage
	logic          valid_s1;
	sdspi_item_t   item_s1;
	logic          advance;

	// result register
	logic          rsp_valid_q;
	sdspi_result_t rsp_q;

	// config registers
	logic [15:0]   timeout_q;
	logic [3:0]    polls_q;

	sdspi_result_t res;
	logic          res_valid;

	// The staged word moves on when the result register is empty or drains
	// this cycle. Words that make no result use the same rule; simple and
	// still one per cycle whenever the output side keeps up.
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd;
		end
	end

	// Sequencer state updates as the staged word advances.
	sdspi_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.item             (item_s1),
		.ready_timeout_ms (timeout_q),
		.response_polls   (polls_q),
		.res              (res),
		.res_valid        (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// res_valid implies advance, so a held word is never overwritten
	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Config must only be written while idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= READY_TIMEOUT_RST;
			polls_q   <= RESPONSE_POLLS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_READY_TIMEOUT:  timeout_q <= cfg_data;
				CFG_RESPONSE_POLLS: polls_q   <= cfg_data[3:0];
			endcase
		end
	end

endmodule

@@ sv/sdspi_engine.sv @@
// Command sequencer: state registers, next-state decode and result word build.
`timescale 1ns / 1ps

module sdspi_engine (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  sdspi_pkg::sdspi_item_t  item,
	input  logic [15:0]             ready_timeout_ms,
	input  logic [3:0]              response_polls,
	output sdspi_pkg::sdspi_result_t res,
	output logic                    res_valid
);
	import sdspi_pkg::*;

	phase_t      phase_q, phase_n;
	logic [5:0]  index_q, index_n;
	logic [31:0] arg_q, arg_n;
	logic        prefix_q, prefix_n;
	logic [2:0]  bcnt_q, bcnt_n;
	logic [3:0]  pcnt_q, pcnt_n;
	logic [15:0] elapsed_q, elapsed_n;
	logic        cs_low_q, cs_low_n;

	// decode
	logic [5:0]  cur_idx;
	logic [31:0] cur_arg;
	logic        is_start, is_rx, resp_req, fin, fin_to, chain, bc_req, bc_short;
	logic [7:0]  fin_r1;
	logic [5:0]  bc_idx;
	logic [3:0]  pcnt_inc;

	always_comb begin
		cur_idx  = prefix_q ? CMD_APP : index_q;
		cur_arg  = prefix_q ? 32'd0 : arg_q;
		is_start = (item.op == OP_START) && (phase_q == PH_IDLE);
		is_rx    = (item.op == OP_RX) && (phase_q != PH_IDLE);
		pcnt_inc = pcnt_q + 4'd1;
		resp_req = is_rx && (((phase_q == PH_SEND) && (bcnt_q >= LAST_CMD_BYTE)
			&& (cur_idx != CMD_STOP)) || (phase_q == PH_STUFF));
		fin    = 1'b0;
		fin_r1 = 8'd0;
		fin_to = 1'b0;
		if (resp_req && (response_polls == 4'd0)) begin
			fin    = 1'b1;
			fin_r1 = R1_NO_RESP;
		end
		if (is_rx && (phase_q == PH_TODESEL)) begin
			fin    = 1'b1;
			fin_r1 = R1_TIMEOUT;
			fin_to = 1'b1;
		end
		if (is_rx && (phase_q == PH_RESP)) begin
			if (!item.rx_byte[7]) begin
				fin    = 1'b1;
				fin_r1 = item.rx_byte;
			end else if ((pcnt_inc >= response_polls) || (pcnt_inc == 4'd0)) begin
				fin    = 1'b1;
				fin_r1 = R1_NO_RESP;
			end
		end
		// a good CMD55 answer goes on to the real command
		chain    = fin && prefix_q && (fin_r1 <= 8'd1);
		bc_req   = is_start || chain;
		bc_idx   = is_start ? (item.app_cmd ? CMD_APP : item.cmd_index) : index_q;
		bc_short = (bc_idx == CMD_GO_IDLE) || (bc_idx == CMD_STOP);
	end

	// next state
	always_comb begin
		phase_n   = phase_q;
		index_n   = index_q;
		arg_n     = arg_q;
		prefix_n  = prefix_q;
		bcnt_n    = bcnt_q;
		pcnt_n    = pcnt_q;
		elapsed_n = elapsed_q;
		cs_low_n  = cs_low_q;
		if ((item.op == OP_TICK) && (elapsed_q != 16'hFFFF)) begin
			elapsed_n = elapsed_q + 16'd1;
		end
		if (is_start) begin
			index_n  = item.cmd_index;
			arg_n    = item.cmd_arg;
			prefix_n = item.app_cmd;
		end
		if (is_rx) begin
			unique case (phase_q)
				PH_DESEL: begin
					cs_low_n = 1'b1;
					phase_n  = PH_SEL;
				end
				PH_SEL: begin
					elapsed_n = 16'd0;
					phase_n   = PH_WAIT;
				end
				PH_WAIT: begin
					if (item.rx_byte == BYTE_IDLE) begin
						bcnt_n  = 3'd0;
						phase_n = PH_SEND;
					end else if (elapsed_q >= ready_timeout_ms) begin
						cs_low_n = 1'b0;
						phase_n  = PH_TODESEL;
					end
				end
				PH_SEND: begin
					if (bcnt_q < LAST_CMD_BYTE) begin
						bcnt_n = bcnt_q + 3'd1;
					end else if (cur_idx == CMD_STOP) begin
						phase_n = PH_STUFF;
					end
				end
				PH_RESP: begin
					if (item.rx_byte[7]) begin
						pcnt_n = pcnt_inc;
					end
				end
				PH_IDLE, PH_TODESEL, PH_STUFF: begin
				end
			endcase
		end
		if (resp_req && (response_polls != 4'd0)) begin
			pcnt_n  = 4'd0;
			phase_n = PH_RESP;
		end
		if (fin) begin
			prefix_n = 1'b0;
			phase_n  = PH_IDLE;
		end
		if (bc_req) begin
			if (bc_short) begin
				if (bc_idx == CMD_GO_IDLE) begin
					cs_low_n = 1'b1;
				end
				bcnt_n  = 3'd0;
				phase_n = PH_SEND;
			end else begin
				cs_low_n = 1'b0;
				phase_n  = PH_DESEL;
			end
		end
	end

	// result word
	always_comb begin
		res_valid           = step && (is_start || is_rx);
		res.kind            = 1'b0;
		res.tx_byte         = BYTE_IDLE;
		res.chip_select_low = cs_low_n;
		res.r1              = 8'd0;
		res.timed_out       = 1'b0;
		res.last            = 1'b1;
		if (bc_req) begin
			res.tx_byte = bc_short ? cmd_byte(bc_idx, 32'd0, 3'd0) : BYTE_IDLE;
		end else if (fin) begin
			res.kind      = 1'b1;
			res.r1        = fin_r1;
			res.timed_out = fin_to;
		end else if (is_rx && (phase_q == PH_WAIT) && (item.rx_byte == BYTE_IDLE)) begin
			res.tx_byte = cmd_byte(cur_idx, cur_arg, 3'd0);
		end else if (is_rx && (phase_q == PH_SEND) && (bcnt_q < LAST_CMD_BYTE)) begin
			res.tx_byte = cmd_byte(cur_idx, cur_arg, bcnt_q + 3'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			index_q   <= 6'd0;
			arg_q     <= 32'd0;
			prefix_q  <= 1'b0;
			bcnt_q    <= 3'd0;
			pcnt_q    <= 4'd0;
			elapsed_q <= 16'd0;
			cs_low_q  <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			index_q   <= index_n;
			arg_q     <= arg_n;
			prefix_q  <= prefix_n;
			bcnt_q    <= bcnt_n;
			pcnt_q    <= pcnt_n;
			elapsed_q <= elapsed_n;
			cs_low_q  <= cs_low_n;
		end
	end

endmodule

@@ sv/sdspi_checker.sv @@
// Port-level checks for the SD SPI command engine, bound to the top level.
`timescale 1ns / 1ps

module sdspi_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     rsp_valid,
	input logic                     rsp_stall,
	input sdspi_pkg::sdspi_result_t rsp
);
	import sdspi_pkg::*;

	// held result word stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// shift words carry no status
	a_shift_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.kind |-> (rsp.r1 == 8'd0) && !rsp.timed_out && rsp.last)
		else $error("shift word carries status");

	// finished words idle MOSI
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind |-> (rsp.tx_byte == BYTE_IDLE))
		else $error("finished word drives MOSI");

	// timeout leaves card deselected with r1 0xFF
	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.timed_out |-> rsp.kind && (rsp.r1 == R1_TIMEOUT)
			&& !rsp.chip_select_low)
		else $error("bad timeout word");

endmodule

bind sd_spi_command_transaction sdspi_checker u_sdspi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

@@ tb/sv/testbench.sv @@
// Testbench for the SD SPI-mode command engine: directed and random commands checked word by word.
`timescale 1ns / 1ps

module testbench;
	import sdspi_pkg::*;

	// op value 3 has no meaning; the engine must drop it
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_WORDS = 800;
	localparam int DRAIN_CYCLES = 10;   // margin past the input stage and result register

	// behavior of the simulated card during one command
	typedef struct packed {
		int         busy_polls;     // non-ready bytes returned before 0xFF
		int         ticks_per_poll; // ms ticks sent ahead of each busy byte
		int         resp_delay;     // bytes with bit 7 set before the R1
		logic [7:0] prefix_r1;      // R1 answered to the CMD55 prefix
		logic [7:0] r1;             // R1 answered to the command itself
		int         noise_pct;      // chance of a stray word per exchange
	} card_t;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          cmd_stall;
	sdspi_item_t   cmd = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	sdspi_result_t rsp;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_index = 1'b0;
	logic [15:0]   cfg_data = '0;

	sd_spi_command_transaction uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Engine predictor: a shadow of the sequencer, stepped once per
	// accepted input word, pushing the result words it should emit.
	// ------------------------------------------------------------------
	phase_t      exp_phase = PH_IDLE;
	logic [5:0]  exp_index = '0;
	logic [31:0] exp_arg = '0;
	logic        exp_prefix = 1'b0;    // CMD55 prefix in progress
	logic [2:0]  exp_frame_pos = '0;   // position in the six-byte frame
	logic [3:0]  exp_polls_seen = '0;
	logic [15:0] exp_elapsed = '0;     // saturating ms counter
	logic        exp_cs_low = 1'b0;
	logic [15:0] reg_ready_timeout = READY_TIMEOUT_RST;
	logic [3:0]  reg_response_polls = RESPONSE_POLLS_RST;

	sdspi_result_t expected_words[$];
	int            words_predicted = 0;
	logic          failed = 1'b0;
	int            mismatch_count = 0;
	int            cycle_count = 0;
	int            burst_left = 0;

	function automatic logic [5:0] active_index();
		return exp_prefix ? CMD_APP : exp_index;
	endfunction

	// byte k of the frame for whichever command is on the wire
	function automatic logic [7:0] frame_byte(input logic [2:0] k);
		logic [5:0]  idx;
		logic [31:0] arg;
		idx = active_index();
		arg = exp_prefix ? 32'd0 : exp_arg;
		case (k)
			3'd0: return 8'h40 | {2'b00, idx};
			3'd1: return arg[31:24];
			3'd2: return arg[23:16];
			3'd3: return arg[15:8];
			3'd4: return arg[7:0];
			default: begin
				if (idx == CMD_GO_IDLE) return 8'h95;
				if (idx == CMD_SEND_IF) return 8'h87;
				if (idx == CMD_APP) return 8'h65;
				if (idx == CMD_APP_OP) return 8'h77;
				return 8'h01;
			end
		endcase
	endfunction

	task automatic push_word(input logic kind, input logic [7:0] tx, input logic [7:0] r1,
			input logic timed_out);
		sdspi_result_t w;
		w.kind = kind;
		w.tx_byte = tx;
		w.chip_select_low = exp_cs_low;
		w.r1 = r1;
		w.timed_out = timed_out;
		w.last = 1'b1;
		expected_words.push_back(w);
		words_predicted++;
	endtask

	// CMD0 selects at once, CMD12 leaves CS alone, the rest go through deselect/select
	task automatic open_command();
		logic [5:0] idx;
		idx = active_index();
		if (idx == CMD_GO_IDLE || idx == CMD_STOP) begin
			if (idx == CMD_GO_IDLE) exp_cs_low = 1'b1;
			exp_frame_pos = '0;
			exp_phase = PH_SEND;
			push_word(1'b0, frame_byte(3'd0), 8'h00, 1'b0);
		end else begin
			exp_cs_low = 1'b0;
			exp_phase = PH_DESEL;
			push_word(1'b0, BYTE_IDLE, 8'h00, 1'b0);
		end
	endtask

	// a good R1 on the prefix rolls straight into the real command
	task automatic close_command(input logic [7:0] r1, input logic timed_out);
		if (exp_prefix && r1 <= 8'd1) begin
			exp_prefix = 1'b0;
			open_command();
		end else begin
			exp_prefix = 1'b0;
			exp_phase = PH_IDLE;
			push_word(1'b1, BYTE_IDLE, r1, timed_out);
		end
	endtask

	task automatic start_response();
		if (reg_response_polls == 4'd0) begin
			close_command(R1_NO_RESP, 1'b0);
		end else begin
			exp_polls_seen = '0;
			exp_phase = PH_RESP;
			push_word(1'b0, BYTE_IDLE, 8'h00, 1'b0);
		end
	endtask

	task automatic engine_step(input sdspi_item_t w);
		case (w.op)
			OP_TICK: begin
				if (exp_elapsed != 16'hFFFF) exp_elapsed++;
			end
			OP_START: begin
				if (exp_phase == PH_IDLE) begin
					exp_index = w.cmd_index;
					exp_prefix = w.app_cmd;
					exp_arg = w.cmd_arg;
					open_command();
				end
			end
			OP_RX: begin
				case (exp_phase)
					PH_DESEL: begin
						exp_cs_low = 1'b1;
						exp_phase = PH_SEL;
						push_word(1'b0, BYTE_IDLE, 8'h00, 1'b0);
					end
					PH_SEL: begin
						exp_elapsed = '0;
						exp_phase = PH_WAIT;
						push_word(1'b0, BYTE_IDLE, 8'h00, 1'b0);
					end
					PH_WAIT: begin
						// timeout is judged only after a byte comes back
						if (w.rx_byte == BYTE_IDLE) begin
							exp_frame_pos = '0;
							exp_phase = PH_SEND;
							push_word(1'b0, frame_byte(3'd0), 8'h00, 1'b0);
						end else if (exp_elapsed < reg_ready_timeout) begin
							push_word(1'b0, BYTE_IDLE, 8'h00, 1'b0);
						end else begin
							exp_cs_low = 1'b0;
							exp_phase = PH_TODESEL;
							push_word(1'b0, BYTE_IDLE, 8'h00, 1'b0);
						end
					end
					PH_TODESEL: close_command(R1_TIMEOUT, 1'b1);
					PH_SEND: begin
						if (exp_frame_pos < LAST_CMD_BYTE) begin
							exp_frame_pos++;
							push_word(1'b0, frame_byte(exp_frame_pos), 8'h00, 1'b0);
						end else if (active_index() == CMD_STOP) begin
							exp_phase = PH_STUFF;
							push_word(1'b0, BYTE_IDLE, 8'h00, 1'b0);
						end else begin
							start_response();
						end
					end
					PH_STUFF: start_response();
					PH_RESP: begin
						if (!w.rx_byte[7]) begin
							close_command(w.rx_byte, 1'b0);
						end else begin
							exp_polls_seen = exp_polls_seen + 4'd1;
							if (exp_polls_seen >= reg_response_polls || exp_polls_seen == 4'd0)
								close_command(R1_NO_RESP, 1'b0);
							else
								push_word(1'b0, BYTE_IDLE, 8'h00, 1'b0);
						end
					end
					default: ; // a byte while idle is dropped
				endcase
			end
			default: ; // unused op
		endcase
	endtask

	// ------------------------------------------------------------------
	// Result side: stall pattern plus word-by-word compare.
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_hold = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run limit reached with %0d words outstanding", $time,
				expected_words.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// mode 0 never stalls, so there are clean stretches as well
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode = $urandom_range(3);
			stall_hold = $urandom_range(250, 40);
		end else begin
			stall_hold = stall_hold - 1;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(99) < 30);
			2: rsp_stall <= ($urandom_range(99) < 80);
			default: rsp_stall <= ((cycle_count % 5) < 2);
		endcase
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			failed = 1'b1;
			if (mismatch_count < 50)
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		sdspi_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_words.size() == 0) begin
				failed = 1'b1;
				if (mismatch_count < 50)
					$display("%0t: result word with none expected, expected none actual %h",
						$time, rsp);
				mismatch_count++;
			end else begin
				want = expected_words.pop_front();
				check_field("kind", want.kind, rsp.kind);
				check_field("tx_byte", want.tx_byte, rsp.tx_byte);
				check_field("chip_select_low", want.chip_select_low, rsp.chip_select_low);
				check_field("r1", want.r1, rsp.r1);
				check_field("timed_out", want.timed_out, rsp.timed_out);
				check_field("last", want.last, rsp.last);
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Sends one word and predicts it at acceptance. Words go out in bursts;
	// valid stays high across a burst and drops only for a gap.
	task automatic send_word(input sdspi_item_t w);
		cmd <= w;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		engine_step(w);
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(99) < 15 ? $urandom_range(12, 7) : $urandom_range(4, 1))
				@(posedge clk);
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(120, 40) : $urandom_range(20);
		end else begin
			burst_left--;
		end
	endtask

	function automatic sdspi_item_t random_word();
		sdspi_item_t w;
		w.op = 2'($urandom_range(3));
		w.cmd_index = 6'($urandom_range(63));
		w.app_cmd = 1'($urandom_range(1));
		w.cmd_arg = $urandom;
		w.rx_byte = 8'($urandom_range(255));
		return w;
	endfunction

	task automatic send_op(input logic [1:0] op, input logic [7:0] rx);
		sdspi_item_t w;
		w = random_word();
		w.op = op;
		w.rx_byte = rx;
		send_word(w);
	endtask

	// stray word: while busy a start is dropped, while idle a byte is dropped
	task automatic send_noise(input logic busy);
		int pick;
		pick = $urandom_range(2);
		if (pick == 0) send_op(busy ? OP_START : OP_RX, 8'($urandom_range(255)));
		else if (pick == 1) send_op(OP_TICK, 8'($urandom_range(255)));
		else send_op(OP_UNUSED, 8'($urandom_range(255)));
	endtask

	// sender pauses until every predicted word is out
	task automatic hold_until_done();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	// idle the block, then write both registers back to back
	task automatic apply_settings(input logic [15:0] ready_ms, input logic [15:0] polls);
		hold_until_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_index <= CFG_READY_TIMEOUT;
		cfg_data <= ready_ms;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		reg_ready_timeout = ready_ms;
		cfg_index <= CFG_RESPONSE_POLLS;
		cfg_data <= polls;
		do @(posedge clk); while (!cfg_ready);
		reg_response_polls = polls[3:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic card_t make_card(input int busy, input int ticks, input int delay,
			input logic [7:0] prefix_r1, input logic [7:0] r1, input int noise);
		card_t c;
		c.busy_polls = busy;
		c.ticks_per_poll = ticks;
		c.resp_delay = delay;
		c.prefix_r1 = prefix_r1;
		c.r1 = r1;
		c.noise_pct = noise;
		return c;
	endfunction

	// Issues a start word, then plays the card until the predictor says the
	// sequence is over. Answers depend on the predicted phase.
	task automatic run_command(input logic [5:0] idx, input logic app, input logic [31:0] arg,
			input card_t card);
		sdspi_item_t w;
		phase_t      seen;
		int          busy_left;
		int          delay_left;
		w = random_word();
		w.op = OP_START;
		w.cmd_index = idx;
		w.app_cmd = app;
		w.cmd_arg = arg;
		send_word(w);
		seen = PH_IDLE;
		busy_left = 0;
		delay_left = 0;
		while (exp_phase != PH_IDLE) begin
			if (exp_phase != seen) begin
				busy_left = card.busy_polls;
				delay_left = card.resp_delay;
				seen = exp_phase;
			end
			if ($urandom_range(99) < card.noise_pct) begin
				send_noise(1'b1);
			end else begin
				w = random_word();
				w.op = OP_RX;
				case (exp_phase)
					PH_WAIT: begin
						if (busy_left > 0) begin
							repeat (card.ticks_per_poll)
								send_op(OP_TICK, 8'($urandom_range(255)));
							w.rx_byte = 8'($urandom_range(254));
							busy_left--;
						end else begin
							w.rx_byte = BYTE_IDLE;
						end
					end
					PH_RESP: begin
						if (delay_left > 0) begin
							w.rx_byte = 8'h80 | 8'($urandom_range(127));
							delay_left--;
						end else begin
							w.rx_byte = exp_prefix ? card.prefix_r1 : card.r1;
						end
					end
					default: ; // byte content is don't-care here
				endcase
				send_word(w);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset settings; smallest and largest index and argument
	task automatic test_field_extremes();
		run_command(CMD_GO_IDLE, 1'b0, 32'h0000_0000, make_card(0, 0, 0, 8'h00, 8'h01, 0));
		run_command(6'd63, 1'b0, 32'hFFFF_FFFF, make_card(2, 0, 9, 8'h00, 8'h00, 0));
	endtask

	// the CMD8, CMD55 and CMD41 CRCs, plus the prefix rolling into CMD41
	task automatic test_crc_commands();
		run_command(CMD_SEND_IF, 1'b0, 32'h0000_01AA, make_card(1, 0, 1, 8'h00, 8'h01, 0));
		run_command(CMD_APP, 1'b0, 32'h5A5A_A5A5, make_card(0, 0, 0, 8'h00, 8'h01, 0));
		run_command(CMD_APP_OP, 1'b1, 32'h4000_0000, make_card(1, 0, 2, 8'h01, 8'h00, 0));
	endtask

	// CMD12 keeps CS and inserts the stuff byte
	task automatic test_stop_stuff_byte();
		run_command(CMD_STOP, 1'b0, 32'h0000_0000, make_card(0, 0, 1, 8'h00, 8'h00, 0));
	endtask

	// CMD55 answering above 1 cuts the application command short
	task automatic test_prefix_abort();
		run_command(6'd23, 1'b1, 32'h0000_0010, make_card(0, 0, 0, 8'h05, 8'h00, 0));
	endtask

	// dropped words: bytes and op 3 while idle, ticks, starts while busy
	task automatic test_ignored_words();
		send_op(OP_RX, 8'h00);
		send_op(OP_UNUSED, 8'hFF);
		send_op(OP_TICK, 8'h5A);
		run_command(6'd17, 1'b0, 32'h1234_5678, make_card(1, 0, 1, 8'h00, 8'h00, 40));
	endtask

	// timeout 0 still polls once; a short timeout reached by ticks, also on a prefix
	task automatic test_ready_timeout();
		apply_settings(16'd0, 16'd10);
		run_command(6'd17, 1'b0, 32'h0000_0200, make_card(3, 0, 0, 8'h00, 8'h00, 0));
		apply_settings(16'd2, 16'd10);
		run_command(6'd24, 1'b0, 32'h0000_0400, make_card(5, 1, 0, 8'h00, 8'h00, 0));
		run_command(CMD_APP_OP, 1'b1, 32'h0, make_card(5, 1, 0, 8'h00, 8'h00, 0));
	endtask

	// zero polls finish without polling; fifteen polls run out or just make it
	task automatic test_no_response();
		apply_settings(16'd500, 16'hFFF0);
		run_command(6'd17, 1'b0, 32'h0, make_card(0, 0, 0, 8'h00, 8'h00, 0));
		run_command(CMD_APP_OP, 1'b1, 32'h0, make_card(0, 0, 0, 8'h00, 8'h00, 0));
		apply_settings(16'd500, 16'd15);
		run_command(6'd9, 1'b0, 32'h0, make_card(0, 0, 20, 8'h00, 8'h00, 0));
		run_command(6'd10, 1'b0, 32'h0, make_card(0, 0, 14, 8'h00, 8'h7F, 0));
	endtask

	// a longer timeout survives the first busy byte and trips on the second
	task automatic test_tick_timeout();
		apply_settings(16'd40, 16'd15);
		run_command(6'd17, 1'b0, 32'h0, make_card(2, 30, 0, 8'h00, 8'h00, 0));
	endtask

	// mostly well-formed commands with random content and a misbehaving card
	task automatic test_random_commands(input int n_words);
		int         stop_at;
		int         pick;
		logic [5:0] idx;
		card_t      card;
		stop_at = words_predicted + n_words;
		while (words_predicted < stop_at) begin
			pick = $urandom_range(9);
			case (pick)
				0: idx = CMD_GO_IDLE;
				1: idx = CMD_SEND_IF;
				2: idx = CMD_STOP;
				3: idx = CMD_APP_OP;
				4: idx = CMD_APP;
				default: idx = 6'($urandom_range(63));
			endcase
			card.busy_polls = $urandom_range(4);
			card.ticks_per_poll = ($urandom_range(3) == 0) ? $urandom_range(3) : 0;
			card.resp_delay = $urandom_range(int'(reg_response_polls) + 2);
			card.prefix_r1 = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(1));
			card.r1 = ($urandom_range(5) == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(127));
			card.noise_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10);
			run_command(idx, ($urandom_range(9) < 3), $urandom, card);
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(3, 1)) send_noise(1'b0);
			if ($urandom_range(19) == 0)
				hold_until_done();
		end
	endtask

	task automatic test_random_settings();
		apply_settings(16'd1, 16'd1);
		test_random_commands(RANDOM_WORDS / 5);
		apply_settings(16'd3, 16'd4);
		test_random_commands(RANDOM_WORDS / 5);
		apply_settings(16'd0, 16'd15);
		test_random_commands(RANDOM_WORDS / 5);
		apply_settings(16'($urandom_range(6)), 16'($urandom_range(65535)));
		test_random_commands(RANDOM_WORDS / 5);
		apply_settings(16'hFFFF, 16'd10);
		test_random_commands(RANDOM_WORDS / 5);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_crc_commands();
		test_stop_stuff_byte();
		test_prefix_abort();
		test_ignored_words();
		test_ready_timeout();
		test_no_response();
		test_tick_timeout();
		test_random_settings();

		// drain, then give trailing words time to show up
		hold_until_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && expected_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sd_spi_command_transaction.f @@
sv/sdspi_pkg.sv
sv/sdspi_engine.sv
sv/sd_spi_command_transaction.sv
sv/sdspi_checker.sv
tb/sv/testbench.sv
